>>> hw/rtl/salsa_pkg.sv
// salsa_pkg: shared types and constants for the salsa20 stream cipher
// used by the controller, the core datapath and the top level
`default_nettype none
package salsa_pkg;
	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_NONCE = 3'd4;
	localparam logic [2:0] REG_ROUND = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;     // load initial state
		logic dround;   // apply one double round
		logic finish;   // add initial state into keystream
	} cmd_t;

	typedef logic [15:0][31:0] block_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] nb, nc, nd, na;
		nb = b ^ rotl(a + d, 7);
		nc = c ^ rotl(nb + a, 9);
		nd = d ^ rotl(nc + nb, 13);
		na = a ^ rotl(nd + nc, 18);
		qr = {na, nb, nc, nd};
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/salsa_core.sv
// salsa_core: keystream datapath, one double round per cycle while cmd.dround is set
// depends on salsa_pkg
`default_nettype none
module salsa_core import salsa_pkg::*; (
	input  wire logic         clk,
	input  wire cmd_t         cmd,
	input  wire block_t       init,
	output block_t            keystream
);
	block_t x_q, init_q, ks_q, c, r;

	always_comb begin
		c = x_q;
		{c[0], c[4], c[8], c[12]}  = qr(x_q[0], x_q[4], x_q[8], x_q[12]);
		{c[5], c[9], c[13], c[1]}  = qr(x_q[5], x_q[9], x_q[13], x_q[1]);
		{c[10], c[14], c[2], c[6]} = qr(x_q[10], x_q[14], x_q[2], x_q[6]);
		{c[15], c[3], c[7], c[11]} = qr(x_q[15], x_q[3], x_q[7], x_q[11]);
		r = c;
		{r[0], r[1], r[2], r[3]}     = qr(c[0], c[1], c[2], c[3]);
		{r[5], r[6], r[7], r[4]}     = qr(c[5], c[6], c[7], c[4]);
		{r[10], r[11], r[8], r[9]}   = qr(c[10], c[11], c[8], c[9]);
		{r[15], r[12], r[13], r[14]} = qr(c[15], c[12], c[13], c[14]);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= init;
			init_q <= init;
		end else if (cmd.dround) begin
			x_q <= r;
		end
		if (cmd.finish) begin
			for (int i = 0; i < 16; i++) ks_q[i] <= x_q[i] + init_q[i];
		end
	end

	assign keystream = ks_q;
endmodule
`default_nettype wire

>>> hw/rtl/salsa_ctrl.sv
// salsa_ctrl: sequencer for block generation and word handshakes
// depends on salsa_pkg
`default_nettype none
module salsa_ctrl import salsa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,      // accepted word needs a new block
	input  wire logic go,         // accepted word without new block
	input  wire logic twenty,
	input  wire logic out_free,
	output cmd_t      cmd,
	output logic      busy,
	output logic      emit
);
	state_t state_q, state_d;
	logic [3:0] cnt_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_ROUND; else if (go) state_d = ST_OUT;
			ST_ROUND: if (cnt_q == 4'd0) state_d = ST_OUT;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.load = start && state_q == ST_IDLE;
		cmd.dround = state_q == ST_ROUND && cnt_q != 4'd0;
		cmd.finish = state_q == ST_ROUND && cnt_q == 4'd0;
		busy = state_q != ST_IDLE;
		emit = state_q == ST_OUT && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) cnt_q <= twenty ? 4'd10 : 4'd6;
			else if (cmd.dround) cnt_q <= cnt_q - 4'd1;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/salsa20_stream_cipher.sv
// salsa20_stream_cipher: top level, registers, word handling and output stage
// depends on salsa_pkg, salsa_ctrl, salsa_core
//
// input channel data_valid/data_ready carries 8-byte words with a byte count
// and an end-of-message flag; output channel result_valid/result_ready
// returns the xored word. one transaction at a time: at word position zero
// a keystream block is generated (6 or 10 double rounds plus load and final
// add), so the first word of a block passes through the load, the double
// rounds and the final add before it reaches the output register; the other
// words of the block go to it directly, and the double-round unit sets the pace.
// a new word is accepted once the previous result sits in the output
// register, so a stalled receiver holds at most two transactions: one in
// the output register and one waiting behind it.
// reset clears the counter, word position, output valid and the registers to
// their defaults (20 rounds). a config write to index 0-5 clears counter and position.
// a word with zero byte count bypasses the keystream and changes no state.
`default_nettype none
module salsa20_stream_cipher import salsa_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        data_valid,
	output logic             data_ready,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  valid_bytes,
	input  wire logic        end_of_message,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [63:0]      result_word,
	output logic [3:0]       result_bytes,
	output logic             result_last
);
	logic [63:0] key0_q, key1_q, key2_q, key3_q, nonce_q;
	logic twenty_q;
	logic [31:0] ctr_q;
	logic [2:0] pos_q;
	logic [63:0] word_q;
	logic [3:0] nb_q;
	logic last_q;
	logic busy, emit, acc, start, go, out_free;
	logic [3:0] nb_sat;
	logic last_eff;
	cmd_t cmd;
	block_t init, ks;
	logic [63:0] ks_word, mask;

	assign out_free = !result_valid || result_ready;
	assign data_ready = !busy;
	assign acc = data_valid && data_ready;
	assign nb_sat = valid_bytes[3] ? 4'd8 : valid_bytes;
	assign last_eff = end_of_message || nb_sat != 4'd8;
	assign start = acc && valid_bytes != 4'd0 && pos_q == 3'd0;
	assign go = acc && !start;

	always_comb begin
		init[0] = SIGMA0;        init[1] = key0_q[31:0];  init[2] = key0_q[63:32];
		init[3] = key1_q[31:0];  init[4] = key1_q[63:32]; init[5] = SIGMA1;
		init[6] = nonce_q[31:0]; init[7] = nonce_q[63:32]; init[8] = ctr_q;
		init[9] = '0;            init[10] = SIGMA2;       init[11] = key2_q[31:0];
		init[12] = key2_q[63:32]; init[13] = key3_q[31:0]; init[14] = key3_q[63:32];
		init[15] = SIGMA3;
	end

	salsa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .go(go), .twenty(twenty_q),
		.out_free(out_free), .cmd(cmd), .busy(busy), .emit(emit)
	);

	salsa_core u_core (.clk(clk), .cmd(cmd), .init(init), .keystream(ks));

	// word position already advanced when the stored word is emitted
	logic [2:0] rpos_q;
	assign ks_word = {ks[{rpos_q, 1'b1}], ks[{rpos_q, 1'b0}]};
	always_comb begin
		mask = '0;
		for (int i = 0; i < 8; i++) if (4'(i) < nb_q) mask[8*i +: 8] = 8'hff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q <= '0; key1_q <= '0; key2_q <= '0; key3_q <= '0; nonce_q <= '0;
			twenty_q <= 1'b1;
			ctr_q <= '0;
			pos_q <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY0:  key0_q <= cfg_data;
					REG_KEY1:  key1_q <= cfg_data;
					REG_KEY2:  key2_q <= cfg_data;
					REG_KEY3:  key3_q <= cfg_data;
					REG_NONCE: nonce_q <= cfg_data;
					REG_ROUND: twenty_q <= cfg_data[0];
					default: ;
				endcase
				if (cfg_index <= REG_ROUND) begin
					ctr_q <= '0;
					pos_q <= '0;
				end
			end else if (acc && valid_bytes != 4'd0) begin
				if (last_eff || pos_q == 3'd7) begin
					ctr_q <= ctr_q + 32'd1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 3'd1;
				end
			end
			if (emit) result_valid <= 1'b1;
			else if (result_ready) result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			word_q <= data_word;
			rpos_q <= pos_q;
			nb_q <= (valid_bytes == 4'd0) ? 4'd0 : nb_sat;
			last_q <= (valid_bytes == 4'd0) ? end_of_message : last_eff;
		end
		if (emit) begin
			result_word <= (word_q ^ ks_word) & mask;
			result_bytes <= nb_q;
			result_last <= last_q;
		end
	end
endmodule
`default_nettype wire

>>> tb/sv/tb_salsa20_stream_cipher.sv
// tb_salsa20_stream_cipher: self-checking testbench for the salsa20 stream cipher
// drives words over valid/ready, predicts each result with its own salsa20 model
// depends on salsa_pkg and salsa20_stream_cipher
`timescale 1ns / 1ps
module tb_salsa20_stream_cipher;
	import salsa_pkg::*;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  nbytes;
		logic        last;
	} cipher_out_t;

	typedef struct {
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        eom;
		bit          fixed;
		cipher_out_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        data_valid = 1'b0;
	logic        data_ready;
	logic [63:0] data_word = '0;
	logic [3:0]  valid_bytes = '0;
	logic        end_of_message = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [63:0] result_word;
	logic [3:0]  result_bytes;
	logic        result_last;

	salsa20_stream_cipher u_top (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [63:0] key_q [4];
	logic [63:0] nonce_q;
	logic        twenty_q;
	logic [31:0] blk_ctr;
	logic [2:0]  word_pos;
	logic [31:0] ks_words [16];

	cipher_out_t expected_q [$];
	int n_errors = 0;
	int n_results = 0;
	int n_sent = 0;
	bit rx_quiet = 1'b0;

	function automatic logic [31:0] rol32(logic [31:0] v, int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void mix(ref logic [31:0] x [16], input int a, b, c, d);
		x[b] ^= rol32(x[a] + x[d], 7);
		x[c] ^= rol32(x[b] + x[a], 9);
		x[d] ^= rol32(x[c] + x[b], 13);
		x[a] ^= rol32(x[d] + x[c], 18);
	endfunction

	task automatic gen_keystream();
		logic [31:0] init [16];
		logic [31:0] x [16];
		init = '{SIGMA0, key_q[0][31:0], key_q[0][63:32], key_q[1][31:0],
			key_q[1][63:32], SIGMA1, nonce_q[31:0], nonce_q[63:32], blk_ctr, 32'd0,
			SIGMA2, key_q[2][31:0], key_q[2][63:32], key_q[3][31:0],
			key_q[3][63:32], SIGMA3};
		x = init;
		for (int dr = 0; dr < (twenty_q ? 10 : 6); dr++) begin
			mix(x, 0, 4, 8, 12);
			mix(x, 5, 9, 13, 1);
			mix(x, 10, 14, 2, 6);
			mix(x, 15, 3, 7, 11);
			mix(x, 0, 1, 2, 3);
			mix(x, 5, 6, 7, 4);
			mix(x, 10, 11, 8, 9);
			mix(x, 15, 12, 13, 14);
		end
		for (int i = 0; i < 16; i++) ks_words[i] = x[i] + init[i];
	endtask

	task automatic encrypt_word(input logic [63:0] data, input logic [3:0] nb_in,
			input logic eom, output cipher_out_t r);
		logic [3:0]  nb;
		logic        last;
		logic [63:0] ks, mask;
		nb = nb_in;
		last = eom;
		if (nb == 0) begin
			r = '{64'd0, 4'd0, last};
			return;
		end
		if (nb > 8) nb = 8;
		if (nb < 8) last = 1'b1;
		if (word_pos == 0) gen_keystream();
		ks = {ks_words[2 * word_pos + 1], ks_words[2 * word_pos]};
		mask = (nb == 8) ? '1 : ((64'd1 << (8 * nb)) - 1);
		r = '{(data ^ ks) & mask, nb, last};
		if (last || word_pos == 3'd7) begin
			blk_ctr++;
			word_pos = 0;
		end else begin
			word_pos++;
		end
	endtask

	task automatic report(string what);
		n_errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// receiver: random stalls, mostly short, a few long, with quiet stretches
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			result_ready <= 1'b1;
			if (!rx_quiet && $urandom_range(0, 3) == 0)
				stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
		end
	end

	// outputs are stable at the falling edge; a handshake seen here completes at the next rise
	always @(negedge clk) begin
		cipher_out_t w;
		if (arst_n && result_valid && result_ready) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected transaction word=%h", result_word));
			end else begin
				w = expected_q.pop_front();
				if (result_word !== w.word)
					report($sformatf("result_word %h, want %h", result_word, w.word));
				if (result_bytes !== w.nbytes)
					report($sformatf("result_bytes %0d, want %0d", result_bytes, w.nbytes));
				if (result_last !== w.last)
					report($sformatf("result_last %0b, want %0b", result_last, w.last));
			end
		end
	end

	task automatic send_word(input logic [63:0] data, input logic [3:0] nb,
			input logic eom, input bit fixed = 0, input cipher_out_t want = '{0, 0, 0});
		int gap;
		cipher_out_t r;
		gap = rx_quiet ? 0 : (($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
			: $urandom_range(0, 2));
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_word <= data;
		valid_bytes <= nb;
		end_of_message <= eom;
		do @(negedge clk); while (!data_ready);
		@(posedge clk);
		encrypt_word(data, nb, eom, r);
		expected_q.push_back(fixed ? want : r);
		n_sent++;
	endtask

	task automatic drain();
		data_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_q[idx] = val;
			REG_NONCE: nonce_q = val;
			REG_ROUND: twenty_q = val[0];
			default: ;
		endcase
		blk_ctr = 0;
		word_pos = 0;
	endtask

	task automatic random_messages(int n_words);
		int left, len, k;
		left = n_words;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: empty words and oversized counts
				send_word({$urandom, $urandom}, $urandom_range(0, 1) ? 4'd0
					: 4'($urandom_range(9, 15)), 1'($urandom));
				left--;
				continue;
			end
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			for (k = 0; k < len && left > 0; k++, left--) begin
				if (k == len - 1)
					send_word({$urandom, $urandom}, 4'($urandom_range(1, 8)), 1'b1);
				else
					send_word({$urandom, $urandom}, 4'd8, 1'b0);
			end
		end
	endtask

	stim_row_t dir_rows [$];

	initial begin
		key_q = '{default: '0};
		nonce_q = '0;
		twenty_q = 1'b1;
		blk_ctr = 0;
		word_pos = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty words have a fixed answer; the rest go through the predictor
		dir_rows.push_back('{64'h0, 4'd8, 1'b0, 0, '{0, 0, 0}});
		for (int i = 1; i < 8; i++)
			dir_rows.push_back('{'1, 4'd8, 1'b0, 0, '{0, 0, 0}});
		dir_rows.push_back('{64'h0123456789abcdef, 4'd8, 1'b1, 0, '{0, 0, 0}});
		dir_rows.push_back('{'1, 4'd0, 1'b0, 1, '{64'd0, 4'd0, 1'b0}});
		dir_rows.push_back('{'1, 4'd0, 1'b1, 1, '{64'd0, 4'd0, 1'b1}});
		dir_rows.push_back('{'1, 4'd1, 1'b0, 0, '{0, 0, 0}});
		dir_rows.push_back('{'1, 4'd7, 1'b0, 0, '{0, 0, 0}});
		dir_rows.push_back('{'1, 4'd8, 1'b0, 0, '{0, 0, 0}});
		dir_rows.push_back('{'1, 4'd15, 1'b0, 0, '{0, 0, 0}});
		dir_rows.push_back('{64'h5555aaaa5555aaaa, 4'd9, 1'b1, 0, '{0, 0, 0}});
		dir_rows.push_back('{64'haaaa5555aaaa5555, 4'd4, 1'b1, 0, '{0, 0, 0}});
		foreach (dir_rows[i])
			send_word(dir_rows[i].data, dir_rows[i].nbytes, dir_rows[i].eom,
				dir_rows[i].fixed, dir_rows[i].want);

		// all-ones key and nonce, 12 rounds
		for (int r = 0; r < 5; r++) write_reg(3'(r), '1);
		write_reg(REG_ROUND, 64'd0);
		random_messages(100);

		rx_quiet = 1'b1;
		random_messages(60);
		rx_quiet = 1'b0;

		write_reg(REG_ROUND, 64'd1);
		random_messages(100);

		for (int ph = 0; ph < 3; ph++) begin
			for (int r = 0; r < 5; r++) write_reg(3'(r), {$urandom, $urandom});
			write_reg(REG_ROUND, 64'(ph[0]));
			random_messages(120);
		end

		for (int r = 0; r < 5; r++) write_reg(3'(r), '0);
		random_messages(40);

		drain();
		$display("sent %0d words across %0d key settings, both round counts, %0d results",
			n_sent, 6, n_results);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout after %0d results", n_results);
		$display("FAILED: results differ");
		$finish;
	end
endmodule
